/* hw/rtl/pilc_pkg.sv */
// Shared types, codes and a saturating helper of the photon interval correlator.
`timescale 1ns / 1ps

package pilc_pkg;

    // Input modes as carried in tuser
    localparam logic [1:0] MODE_PHOTON = 2'd0;
    localparam logic [1:0] MODE_LSTART = 2'd1;
    localparam logic [1:0] MODE_LEND   = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_SAMPLE_TIME = 1'b0;
    localparam logic CFG_DELAY_BINS  = 1'b1;

    localparam int INTERVAL_W = 32;
    localparam int LAG_W      = 5;
    localparam int TICK_W     = 16;
    localparam int DELAY_W    = 6;
    localparam int SUM_W      = 48;
    localparam int CLR_W      = 32;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 272;

    // Classified command kinds
    typedef enum logic [1:0] {
        K_PHOTON = 2'd0,
        K_LSTART = 2'd1,
        K_LEND   = 2'd2,
        K_READ   = 2'd3
    } t_kind;

    // One queued command word
    typedef struct packed {
        t_kind                   kind;
        logic [INTERVAL_W-1:0]   interval;
        logic [LAG_W-1:0]        lag;
    } t_cmd;

    // Saturating add into a 48-bit sum
    function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                   input logic [63:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b[SUM_W-1:0]};
        if ((b[63:SUM_W] != '0) || s[SUM_W]) begin
            return '1;
        end
        return s[SUM_W-1:0];
    endfunction

endpackage

/* hw/rtl/pilc_front.sv */
// Front end: accepts stream words, classifies the mode and queues commands.
`timescale 1ns / 1ps

module pilc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [pilc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // interval, lag_index, pad
    input  logic [1:0]                          s_axis_tuser,  // mode
    output logic                                o_cmd_valid,
    input  logic                                i_cmd_ready,
    output pilc_pkg::t_cmd                      o_cmd
);

    pilc_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    pilc_pkg::t_cmd w_cmd;
    logic           w_push;
    logic           w_pop;

    // Classify the incoming word
    always_comb begin
        w_cmd.interval = s_axis_tdata[31:0];
        w_cmd.lag      = s_axis_tdata[36:32];
        case (s_axis_tuser)
            pilc_pkg::MODE_PHOTON: w_cmd.kind = pilc_pkg::K_PHOTON;
            pilc_pkg::MODE_LSTART: w_cmd.kind = pilc_pkg::K_LSTART;
            pilc_pkg::MODE_LEND:   w_cmd.kind = pilc_pkg::K_LEND;
            default:               w_cmd.kind = pilc_pkg::K_READ;
        endcase
    end

    assign s_axis_tready = (r_cnt != 2'd2);
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign o_cmd_valid   = (r_cnt != 2'd0);
    assign w_pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd         = r_q[r_rp];

    // Two-word queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // Queue pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

/* hw/rtl/pilc_div.sv */
// Restoring divider, one quotient bit a cycle, for gap bin counts.
`timescale 1ns / 1ps

module pilc_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [pilc_pkg::INTERVAL_W-1:0]   i_dividend,
    input  logic [pilc_pkg::TICK_W-1:0]       i_divisor,
    output logic                              o_done,
    output logic [pilc_pkg::INTERVAL_W-1:0]   o_quo,
    output logic [pilc_pkg::TICK_W-1:0]       o_rem
);

    logic                                r_busy;
    logic [4:0]                          r_cnt;
    logic [pilc_pkg::INTERVAL_W-1:0]     r_q;
    logic [pilc_pkg::TICK_W-1:0]         r_r;
    logic [pilc_pkg::TICK_W-1:0]         r_d;
    logic [pilc_pkg::TICK_W:0]           w_sh;
    logic [pilc_pkg::TICK_W:0]           w_diff;
    logic                                w_ge;

    // Shift in the next dividend bit and try the subtract
    assign w_sh   = {r_r, r_q[pilc_pkg::INTERVAL_W-1]};
    assign w_diff = w_sh - {1'b0, r_d};
    assign w_ge   = (w_sh >= {1'b0, r_d});

    assign o_done = !r_busy;
    assign o_quo  = r_q;
    assign o_rem  = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == 5'd31)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= 5'd0;
            r_q   <= i_dividend;
            r_r   <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 5'd1;
            r_q   <= {r_q[pilc_pkg::INTERVAL_W-2:0], w_ge};
            r_r   <= w_ge ? w_diff[pilc_pkg::TICK_W-1:0] : w_sh[pilc_pkg::TICK_W-1:0];
        end
    end

endmodule

/* hw/rtl/pilc_back.sv */
// Back end: binning, delay ring, lag walk with multiply-add, totals and readout.
`timescale 1ns / 1ps

module pilc_back #(
    parameter int NUM_LAGS       = 32,
    parameter int MAX_DELAY_BINS = 32,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_index,
    input  logic [pilc_pkg::TICK_W-1:0]       i_cfg_data,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_ready,
    input  pilc_pkg::t_cmd                    i_cmd,
    output logic                              o_div_start,
    output logic [pilc_pkg::INTERVAL_W-1:0]   o_div_dividend,
    output logic [pilc_pkg::TICK_W-1:0]       o_div_divisor,
    input  logic                              i_div_done,
    input  logic [pilc_pkg::INTERVAL_W-1:0]   i_div_quo,
    input  logic [pilc_pkg::TICK_W-1:0]       i_div_rem,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [pilc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int RING_DEPTH = NUM_LAGS + MAX_DELAY_BINS;
    localparam int AW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int LLW = $clog2(RING_DEPTH + 1) + 1;
    localparam int LW  = (NUM_LAGS > 1) ? $clog2(NUM_LAGS) : 1;
    localparam int PW  = 2 * COUNT_WIDTH;
    localparam int SW  = pilc_pkg::SUM_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CLOSE = 9'b000000010,
        S_RD    = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_WR    = 9'b000010000,
        S_DIVW  = 9'b000100000,
        S_SHIFT = 9'b001000000,
        S_LRD   = 9'b010000000,
        S_LOUT  = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        AF_NONE = 2'd0,
        AF_GAP  = 2'd1,
        AF_LEND = 2'd2
    } t_after;

    // Control state
    t_state                       r_state,  n_state;
    t_after                       r_after,  n_after;
    logic [pilc_pkg::TICK_W-1:0]  r_st,     n_st;
    logic [pilc_pkg::DELAY_W-1:0] r_delay,  n_delay;
    logic [COUNT_WIDTH-1:0]       r_bc,     n_bc;
    logic [pilc_pkg::TICK_W-1:0]  r_tl,     n_tl;
    logic [AW-1:0]                r_wp,     n_wp;
    logic [AW-1:0]                r_dp,     n_dp;
    logic [AW-1:0]                r_idx,    n_idx;
    logic [LW-1:0]                r_k,      n_k;
    logic                         r_single, n_single;
    logic                         r_oor,    n_oor;
    logic [COUNT_WIDTH-1:0]       r_cnt,    n_cnt;
    logic [LLW-1:0]               r_shift,  n_shift;
    logic [SW-1:0]                r_pt,     n_pt;
    logic [SW-1:0]                r_bt,     n_bt;
    logic [pilc_pkg::CLR_W-1:0]   r_clr,    n_clr;
    logic                         r_fresh,  n_fresh;
    logic [RING_DEPTH-1:0]        r_rvld,   n_rvld;
    logic [NUM_LAGS-1:0]          r_svld,   n_svld;
    logic                         r_ovalid, n_ovalid;
    // Datapath registers
    logic [PW-1:0]                r_prod;
    logic [COUNT_WIDTH-1:0]       r_v;
    logic [COUNT_WIDTH-1:0]       r_rq;
    logic                         r_rq_vld;
    logic [SW-1:0]                r_ps_q, r_zs_q, r_ds_q;
    logic                         r_svq;
    logic [pilc_pkg::OUT_DATA_W-1:0] r_odata;

    // Memories
    logic [COUNT_WIDTH-1:0] r_ring [RING_DEPTH];
    logic [SW-1:0]          r_psum [NUM_LAGS];
    logic [SW-1:0]          r_zsum [NUM_LAGS];
    logic [SW-1:0]          r_dsum [NUM_LAGS];

    logic                    ring_we;
    logic [AW-1:0]           ring_wa;
    logic [COUNT_WIDTH-1:0]  ring_wd;
    logic                    sum_we;
    logic                    out_load;

    logic [pilc_pkg::TICK_W-1:0]  eff_st;
    logic [LLW-1:0]               effd_n;
    logic [LLW-1:0]               effd;
    logic [LLW-1:0]               ring_l;
    logic [AW-1:0]                wp_back, dp_back, idx_inc;
    logic [COUNT_WIDTH-1:0]       bc_inc;
    logic [COUNT_WIDTH-1:0]       ring_v;
    logic [SW-1:0]                ps_e, zs_e, ds_e;
    logic                         fin_close;
    logic [pilc_pkg::TICK_W-1:0]  tl_fin;
    logic                         wr_last;

    // Configuration and derived lengths
    always_comb begin
        n_st    = r_st;
        n_delay = r_delay;
        if (i_cfg_valid) begin
            if (i_cfg_index == pilc_pkg::CFG_SAMPLE_TIME) begin
                n_st = i_cfg_data;
            end else begin
                n_delay = i_cfg_data[pilc_pkg::DELAY_W-1:0];
            end
        end
    end

    assign eff_st  = (r_st == '0) ? pilc_pkg::TICK_W'(1) : r_st;
    assign effd    = (32'(r_delay) > MAX_DELAY_BINS) ? LLW'(MAX_DELAY_BINS) : LLW'(r_delay);
    assign effd_n  = (32'(n_delay) > MAX_DELAY_BINS) ? LLW'(MAX_DELAY_BINS) : LLW'(n_delay);
    assign ring_l  = LLW'(NUM_LAGS) + effd;
    assign wp_back = (r_wp == '0) ? AW'(ring_l - LLW'(1)) : r_wp - AW'(1);
    assign dp_back = (r_dp == '0) ? AW'(ring_l - LLW'(1)) : r_dp - AW'(1);
    assign idx_inc = ((LLW'(r_idx) + LLW'(1)) >= ring_l) ? '0 : r_idx + AW'(1);
    assign bc_inc  = (r_bc == '1) ? r_bc : r_bc + COUNT_WIDTH'(1);
    assign ring_v  = r_rq_vld ? r_rq : '0;
    assign ps_e    = r_svq ? r_ps_q : '0;
    assign zs_e    = r_svq ? r_zs_q : '0;
    assign ds_e    = r_svq ? r_ds_q : '0;
    assign fin_close = (i_div_rem == eff_st - pilc_pkg::TICK_W'(1));
    assign tl_fin    = eff_st - i_div_rem - pilc_pkg::TICK_W'(1);
    assign wr_last   = r_single || (r_k == LW'(NUM_LAGS - 1));

    assign o_div_divisor = eff_st;
    assign o_cmd_ready   = (r_state == S_IDLE);

    // Sequencer
    always_comb begin
        n_state  = r_state;   n_after  = r_after;   n_bc    = r_bc;
        n_tl     = r_tl;      n_wp     = r_wp;      n_dp    = r_dp;
        n_idx    = r_idx;     n_k      = r_k;       n_single = r_single;
        n_oor    = r_oor;     n_cnt    = r_cnt;     n_shift = r_shift;
        n_pt     = r_pt;      n_bt     = r_bt;      n_clr   = r_clr;
        n_fresh  = r_fresh;   n_rvld   = r_rvld;    n_svld  = r_svld;
        ring_we  = 1'b0;      ring_wa  = r_wp;      ring_wd = r_bc;
        sum_we   = 1'b0;      out_load = 1'b0;
        o_div_start    = 1'b0;
        o_div_dividend = i_cmd.interval - 32'(r_tl);

        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid && (i_cfg_index == pilc_pkg::CFG_DELAY_BINS)) begin
                    n_rvld = '0;
                    n_wp   = '0;
                    n_dp   = AW'(effd_n);
                end
                if (i_cmd_valid) begin
                    case (i_cmd.kind)
                        pilc_pkg::K_PHOTON: begin
                            n_fresh = 1'b0;
                            if (i_cmd.interval < 32'(r_tl)) begin
                                n_tl = r_tl - i_cmd.interval[pilc_pkg::TICK_W-1:0];
                                n_bc = bc_inc;
                            end else if (i_cmd.interval == 32'(r_tl)) begin
                                n_bc    = bc_inc;
                                n_after = AF_NONE;
                                n_state = S_CLOSE;
                            end else begin
                                o_div_start    = 1'b1;
                                o_div_dividend = i_cmd.interval - 32'(r_tl) - 32'd1;
                                n_after        = AF_GAP;
                                n_state        = S_CLOSE;
                            end
                        end
                        pilc_pkg::K_LSTART: begin
                            if (!r_fresh) begin
                                n_bc    = '0;
                                n_tl    = eff_st;
                                n_fresh = 1'b1;
                                n_clr   = (r_clr == '1) ? r_clr : r_clr + 32'd1;
                                n_rvld  = '0;
                                n_wp    = '0;
                                n_dp    = AW'(effd);
                            end
                        end
                        pilc_pkg::K_LEND: begin
                            if (i_cmd.interval >= 32'(r_tl)) begin
                                o_div_start = 1'b1;
                                n_fresh     = 1'b0;
                                n_after     = AF_LEND;
                                n_state     = S_CLOSE;
                            end
                        end
                        default: begin
                            n_k     = LW'(i_cmd.lag);
                            n_oor   = (32'(i_cmd.lag) >= NUM_LAGS);
                            n_state = S_LRD;
                        end
                    endcase
                end
            end
            // Close the bin: write it to the ring and start the lag walk
            S_CLOSE: begin
                n_wp    = wp_back;
                n_dp    = dp_back;
                ring_we = 1'b1;
                ring_wa = wp_back;
                ring_wd = r_bc;
                n_rvld[wp_back] = 1'b1;
                n_idx    = dp_back;
                n_k      = '0;
                n_cnt    = r_bc;
                n_single = 1'b0;
                n_tl     = eff_st;
                n_bt     = pilc_pkg::sat_add48(r_bt, 64'd1);
                n_pt     = pilc_pkg::sat_add48(r_pt, 64'(r_bc));
                n_bc     = '0;
                n_state  = S_RD;
            end
            S_RD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_WR;
            end
            // Write back the three sums of this lag, then advance to the next lag or end the walk
            S_WR: begin
                sum_we = 1'b1;
                n_svld[r_k] = 1'b1;
                if (wr_last) begin
                    n_state = (r_after == AF_NONE) ? S_IDLE : S_DIVW;
                end else begin
                    n_k     = r_k + LW'(1);
                    n_idx   = idx_inc;
                    n_state = S_RD;
                end
            end
            // Gap handling once the bin count is known
            S_DIVW: begin
                if (i_div_done) begin
                    n_bt    = pilc_pkg::sat_add48(r_bt, 64'(i_div_quo));
                    n_state = S_IDLE;
                    if (r_after == AF_GAP) begin
                        n_after = AF_NONE;
                        if (i_div_quo <= 32'(ring_l)) begin
                            if (i_div_quo == '0) begin
                                n_bc    = COUNT_WIDTH'(1);
                                n_state = fin_close ? S_CLOSE : S_IDLE;
                                if (!fin_close) begin
                                    n_tl = tl_fin;
                                end
                            end else begin
                                n_shift = LLW'(i_div_quo);
                                n_state = S_SHIFT;
                            end
                        end else begin
                            n_rvld = '0;
                            n_wp   = '0;
                            n_dp   = AW'(effd);
                            if (fin_close) begin
                                n_bt    = pilc_pkg::sat_add48(r_bt, 64'(i_div_quo) + 64'd1);
                                n_pt    = pilc_pkg::sat_add48(r_pt, 64'd1);
                                ring_we = 1'b1;
                                ring_wa = '0;
                                ring_wd = COUNT_WIDTH'(1);
                                n_rvld[0] = 1'b1;
                                if (effd == '0) begin
                                    n_cnt    = COUNT_WIDTH'(1);
                                    n_k      = '0;
                                    n_idx    = '0;
                                    n_single = 1'b1;
                                    n_state  = S_RD;
                                end
                            end else begin
                                n_bc = COUNT_WIDTH'(1);
                                n_tl = tl_fin;
                            end
                        end
                    end
                end
            end
            // Shift one empty bin into the ring per cycle
            S_SHIFT: begin
                n_wp    = wp_back;
                n_dp    = dp_back;
                n_rvld[wp_back] = 1'b0;
                n_shift = r_shift - LLW'(1);
                if (r_shift == LLW'(1)) begin
                    n_bc    = COUNT_WIDTH'(1);
                    n_state = fin_close ? S_CLOSE : S_IDLE;
                    if (!fin_close) begin
                        n_tl = tl_fin;
                    end
                end
            end
            S_LRD: begin
                n_state = S_LOUT;
            end
            // Hand the readout to the output register when free
            S_LOUT: begin
                if (!r_ovalid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;   r_after <= AF_NONE;
            r_st     <= pilc_pkg::TICK_W'(1);
            r_delay  <= '0;       r_bc    <= '0;
            r_tl     <= pilc_pkg::TICK_W'(1);
            r_wp     <= '0;       r_dp    <= '0;
            r_idx    <= '0;       r_k     <= '0;
            r_single <= 1'b0;     r_oor   <= 1'b0;
            r_cnt    <= '0;       r_shift <= '0;
            r_pt     <= '0;       r_bt    <= '0;
            r_clr    <= 32'd1;    r_fresh <= 1'b1;
            r_rvld   <= '0;       r_svld  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;  r_after <= n_after;
            r_st     <= n_st;     r_delay <= n_delay;
            r_bc     <= n_bc;     r_tl    <= n_tl;
            r_wp     <= n_wp;     r_dp    <= n_dp;
            r_idx    <= n_idx;    r_k     <= n_k;
            r_single <= n_single; r_oor   <= n_oor;
            r_cnt    <= n_cnt;    r_shift <= n_shift;
            r_pt     <= n_pt;     r_bt    <= n_bt;
            r_clr    <= n_clr;    r_fresh <= n_fresh;
            r_rvld   <= n_rvld;   r_svld  <= n_svld;
            r_ovalid <= n_ovalid;
        end
    end

    // Ring memory
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_wa] <= ring_wd;
        end
        r_rq     <= r_ring[r_idx];
        r_rq_vld <= r_rvld[r_idx];
    end

    // Lag sum memories
    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            r_psum[r_k] <= pilc_pkg::sat_add48(ps_e, 64'(r_prod));
            r_zsum[r_k] <= pilc_pkg::sat_add48(zs_e, 64'(r_cnt));
            r_dsum[r_k] <= pilc_pkg::sat_add48(ds_e, 64'(r_v));
        end
        r_ps_q <= r_psum[r_k];
        r_zs_q <= r_zsum[r_k];
        r_ds_q <= r_dsum[r_k];
        r_svq  <= r_svld[r_k];
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL) begin
            r_prod <= PW'(ring_v) * PW'(r_cnt);
            r_v    <= ring_v;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_odata <= {r_clr, r_bt, r_pt,
                        r_oor ? {SW{1'b0}} : ds_e,
                        r_oor ? {SW{1'b0}} : zs_e,
                        r_oor ? {SW{1'b0}} : ps_e};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

/* hw/rtl/photon_interval_linear_correlator.sv */
// Top level of the linear photon interval correlator.
`timescale 1ns / 1ps
//
// Photon intervals, line marks and lag reads arrive on the s_axis channel;
// tuser carries the mode (photon, line start, line end, read lag). Only a
// lag read gives a word on m_axis: the three sums of that lag and the
// photon, bin and chain-clear totals. Registers (sample time, delay bins)
// are written on the cfg channel, which is always ready.
// A two-word command queue parts the input from the sequencer, so words
// are taken while a readout waits on m_axis; the output register holds
// its word until m_axis_tready.
// A photon inside a bin is handled in the idle state; closing a bin walks
// every lag through the shared multiply-add, in read, multiply and write
// states per lag. A gap shifts one empty bin into the ring per cycle (at
// most NUM_LAGS+MAX_DELAY_BINS) and waits for the bin divider, which runs
// during the walk. A lag read passes S_LRD and S_LOUT into the output
// register, once free. Synchronous reset clears the queue, the ring, all
// sums and totals, and sets the chain-clear count to one.

module photon_interval_linear_correlator #(
    parameter int NUM_LAGS       = 32,
    parameter int MAX_DELAY_BINS = 32,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pilc_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // interval, lag_index, pad
    input  logic [1:0]                        s_axis_tuser,  // mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // product_sum, zero_time_sum, delayed_sum, total_photons, total_bins, chain_clears
    output logic [pilc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [pilc_pkg::TICK_W-1:0]       i_cfg_data
);

    pilc_pkg::t_cmd                    cmd;
    logic                              cmd_valid;
    logic                              cmd_ready;
    logic                              div_start;
    logic [pilc_pkg::INTERVAL_W-1:0]   div_dividend;
    logic [pilc_pkg::TICK_W-1:0]       div_divisor;
    logic                              div_done;
    logic [pilc_pkg::INTERVAL_W-1:0]   div_quo;
    logic [pilc_pkg::TICK_W-1:0]       div_rem;

    assign o_cfg_ready = 1'b1;

    pilc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (cmd_valid),
        .i_cmd_ready   (cmd_ready),
        .o_cmd         (cmd)
    );

    pilc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    pilc_back #(
        .NUM_LAGS       (NUM_LAGS),
        .MAX_DELAY_BINS (MAX_DELAY_BINS),
        .COUNT_WIDTH    (COUNT_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd_valid    (cmd_valid),
        .o_cmd_ready    (cmd_ready),
        .i_cmd          (cmd),
        .o_div_start    (div_start),
        .o_div_dividend (div_dividend),
        .o_div_divisor  (div_divisor),
        .i_div_done     (div_done),
        .i_div_quo      (div_quo),
        .i_div_rem      (div_rem),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

endmodule

/* hw/rtl/pilc_checker.sv */
// Port-level checks of the correlator, bound to the top level.
`timescale 1ns / 1ps

module pilc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pilc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // Hold a stalled word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // Drop any word on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Chain clear count starts at one and never wraps
    a_clears_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[271:240] != 32'd0))
        else $error("chain clear count is zero");

    // A lag's zero-time sum cannot exceed the photons binned
    a_zero_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[95:48] <= m_axis_tdata[191:144]))
        else $error("zero-time sum above photon total");

endmodule

bind photon_interval_linear_correlator pilc_checker u_pilc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
